FILE: hdl/fls_pkg.sv
// ----------------------------------------------------------------------------
// fls_pkg
// Shared types and stream field layout for the feedback level scheduler.
// ----------------------------------------------------------------------------
package fls_pkg;

    // request kind, carried on s_tuser
    typedef enum logic {
        CMD_ADMIT = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    localparam int SLOT_BITS = 4;
    localparam int SVC_BITS  = 16;
    localparam int OUT_TIME_BITS = 16;

    // s_tdata: slot, svc_units, zero fill
    localparam int S_SLOT_LSB = 0;
    localparam int S_SVC_LSB  = S_SLOT_LSB + SLOT_BITS;
    localparam int S_TDATA_W  = ((S_SVC_LSB + SVC_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W  = 1;

    // m_tdata: run_slot, done_time, turnaround, zero fill
    localparam int M_SLOT_LSB = 0;
    localparam int M_FIN_LSB  = M_SLOT_LSB + SLOT_BITS;
    localparam int M_TURN_LSB = M_FIN_LSB + OUT_TIME_BITS;
    localparam int M_USED_W   = M_TURN_LSB + OUT_TIME_BITS;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // m_tuser: run_valid, finished
    localparam int M_RUN_BIT  = 0;
    localparam int M_FIN_BIT  = 1;
    localparam int M_TUSER_W  = 2;

endpackage

FILE: hdl/fls_pick.sv
// ----------------------------------------------------------------------------
// fls_pick
// Compare tree that selects the ready slot with the lowest (level, slot).
// ----------------------------------------------------------------------------
module fls_pick #(
    parameter int SLOT_COUNT = 16,
    parameter int LVL_W      = 4
) (
    input  logic [SLOT_COUNT-1:0]            ready,
    input  logic [SLOT_COUNT-1:0][LVL_W-1:0] level,
    output logic                             found,
    output logic [$clog2(SLOT_COUNT)-1:0]    pick_idx,
    output logic [SLOT_COUNT-1:0]            grant
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int NPOW   = 1 << SLOT_W;
    localparam int NODES  = 2 * NPOW - 1;

    // heap layout: node k has children 2k+1 and 2k+2, leaves start at NPOW-1
    logic             node_vld [NODES];
    logic [LVL_W-1:0] node_lvl [NODES];
    logic [SLOT_W-1:0] node_idx [NODES];

    genvar g;
    generate
        for (g = 0; g < NPOW; g++) begin : g_leaf
            if (g < SLOT_COUNT) begin : g_real
                assign node_vld[NPOW-1+g] = ready[g];
                assign node_lvl[NPOW-1+g] = level[g];
            end else begin : g_pad
                assign node_vld[NPOW-1+g] = 1'b0;
                assign node_lvl[NPOW-1+g] = '0;
            end
            assign node_idx[NPOW-1+g] = SLOT_W'(g);
        end

        for (g = 0; g < NPOW - 1; g++) begin : g_node
            logic take_left;
            // left side holds the lower slots, so it wins a level tie
            assign take_left = node_vld[2*g+1] &&
                               (!node_vld[2*g+2] || node_lvl[2*g+1] <= node_lvl[2*g+2]);
            assign node_vld[g] = node_vld[2*g+1] || node_vld[2*g+2];
            assign node_lvl[g] = take_left ? node_lvl[2*g+1] : node_lvl[2*g+2];
            assign node_idx[g] = take_left ? node_idx[2*g+1] : node_idx[2*g+2];
        end

        for (g = 0; g < SLOT_COUNT; g++) begin : g_grant
            assign grant[g] = node_vld[0] && (node_idx[0] == SLOT_W'(g));
        end
    endgenerate

    assign found    = node_vld[0];
    assign pick_idx = node_idx[0];

endmodule

FILE: hdl/feedback_level_scheduler_core.sv
// ----------------------------------------------------------------------------
// feedback_level_scheduler_core
// Feedback scheduler with a one-unit quantum: admits jobs into slots and on
// each tick runs the ready job with the lowest (level, slot).
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser
//  s_      | in  | slot[3:0], svc_units[19:4]              | cmd (0 admit, 1 tick)
//  m_      | out | run_slot[3:0], done_time[19:4],         | run_valid[0],
//          |     | turnaround[35:20]                       | finished[1]
//
//  one request a cycle unless a tick waits: input register, select/update
//  logic, result register; a tick result reaches m_ through both registers
//  the per-slot compare tree and the state update run in the same cycle
//  admits give no result and never wait on the m_ side
//  a tick waits in the input register while the result register is full
//  aresetn clears all slots, the time counter and both valid flags
// ----------------------------------------------------------------------------
module feedback_level_scheduler_core #(
    parameter int SLOT_COUNT = 16,
    parameter int LEVEL_MAX  = 15,
    parameter int TIME_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fls_pkg::S_TDATA_W-1:0] s_tdata,  // slot, svc_units, zero fill
    input  logic [fls_pkg::S_TUSER_W-1:0] s_tuser,  // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fls_pkg::M_TDATA_W-1:0] m_tdata,  // run_slot, done_time, turnaround, zero fill
    output logic [fls_pkg::M_TUSER_W-1:0] m_tuser   // run_valid, finished
);

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int LVL_W     = $clog2(LEVEL_MAX + 1);
    localparam int SVC_W     = fls_pkg::SVC_BITS;
    localparam int OT_W      = fls_pkg::OUT_TIME_BITS;
    localparam int TIME_EXT_W = (TIME_BITS > OT_W) ? TIME_BITS : OT_W;
    localparam int IDX_EXT_W = (SLOT_W > fls_pkg::SLOT_BITS) ? SLOT_W : fls_pkg::SLOT_BITS;

    // input register
    logic                          in_vld_reg, in_vld_next;
    logic                          cmd_reg;
    logic [fls_pkg::SLOT_BITS-1:0] slot_reg;
    logic [SVC_W-1:0]              svc_reg;

    // scheduler state
    logic [SLOT_COUNT-1:0]            ready_reg, ready_next;
    logic [SLOT_COUNT-1:0]            last_oh_reg, last_oh_next;
    logic                             pend_reg, pend_next;
    logic [TIME_BITS-1:0]             now_reg, now_next;
    logic [SVC_W-1:0]                 rem_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0][LVL_W-1:0] lvl_reg;
    logic [TIME_BITS-1:0]             arr_reg [SLOT_COUNT];

    // result register
    logic                          out_vld_reg, out_vld_next;
    logic                          run_vld_reg;
    logic [fls_pkg::SLOT_BITS-1:0] run_slot_reg;
    logic                          fin_reg;
    logic [OT_W-1:0]               fin_time_reg;
    logic [OT_W-1:0]               turn_reg;

    logic                             proc, is_tick, s_fire;
    logic                             other_rdy, demote;
    logic [SLOT_COUNT-1:0][LVL_W-1:0] lvl_eff;
    logic [SLOT_COUNT-1:0]            wr_hit;
    logic                             found;
    logic [SLOT_W-1:0]                pick_idx;
    logic [SLOT_COUNT-1:0]            grant;
    logic [SVC_W-1:0]                 rem_sel;
    logic [TIME_BITS-1:0]             arr_sel;
    logic                             done;
    logic [TIME_BITS-1:0]             fin_t, turn_t;
    logic [TIME_EXT_W-1:0]            fin_ext, turn_ext;
    logic [IDX_EXT_W-1:0]             idx_ext;

    assign is_tick  = (cmd_reg == fls_pkg::CMD_TICK);
    assign proc     = in_vld_reg && (!is_tick || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc;
    assign s_fire   = s_tvalid && s_tready;

    // demotion of the last runner is settled before the pick
    assign other_rdy = |(ready_reg & ~last_oh_reg);
    assign demote    = pend_reg && |(ready_reg & last_oh_reg) && other_rdy;

    always_comb begin
        rem_sel = '0;
        arr_sel = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (demote && last_oh_reg[i] && lvl_reg[i] < LVL_W'(LEVEL_MAX)) begin
                lvl_eff[i] = lvl_reg[i] + LVL_W'(1);
            end else begin
                lvl_eff[i] = lvl_reg[i];
            end
            wr_hit[i] = (32'(slot_reg) == i);
            rem_sel   = rem_sel | (grant[i] ? rem_reg[i] : '0);
            arr_sel   = arr_sel | (grant[i] ? arr_reg[i] : '0);
        end
    end

    fls_pick #(
        .SLOT_COUNT (SLOT_COUNT),
        .LVL_W      (LVL_W)
    ) u_pick (
        .ready    (ready_reg),
        .level    (lvl_eff),
        .found    (found),
        .pick_idx (pick_idx),
        .grant    (grant)
    );

    assign done     = found && (rem_sel == SVC_W'(1));
    assign fin_t    = now_reg + TIME_BITS'(1);
    assign turn_t   = fin_t - arr_sel;
    assign fin_ext  = TIME_EXT_W'(fin_t);
    assign turn_ext = TIME_EXT_W'(turn_t);
    assign idx_ext  = IDX_EXT_W'(pick_idx);

    always_comb begin
        in_vld_next  = in_vld_reg;
        out_vld_next = out_vld_reg;
        ready_next   = ready_reg;
        last_oh_next = last_oh_reg;
        pend_next    = pend_reg;
        now_next     = now_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end
        if (proc && is_tick) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
        if (proc) begin
            if (is_tick) begin
                if (done) begin
                    ready_next = ready_reg & ~grant;
                end
                if (found) begin
                    last_oh_next = grant;
                end
                pend_next = found && !done;
                now_next  = now_reg + TIME_BITS'(1);
            end else if (svc_reg != '0) begin
                ready_next = ready_reg | wr_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            ready_reg   <= '0;
            last_oh_reg <= '0;
            pend_reg    <= 1'b0;
            now_reg     <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            ready_reg   <= ready_next;
            last_oh_reg <= last_oh_next;
            pend_reg    <= pend_next;
            now_reg     <= now_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg  <= s_tuser[0];
            slot_reg <= s_tdata[fls_pkg::S_SLOT_LSB +: fls_pkg::SLOT_BITS];
            svc_reg  <= s_tdata[fls_pkg::S_SVC_LSB +: SVC_W];
        end
        if (proc && is_tick) begin
            run_vld_reg  <= found;
            run_slot_reg <= found ? idx_ext[fls_pkg::SLOT_BITS-1:0] : '0;
            fin_reg      <= done;
            fin_time_reg <= done ? fin_ext[OT_W-1:0] : '0;
            turn_reg     <= done ? turn_ext[OT_W-1:0] : '0;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (proc && is_tick) begin
                lvl_reg[i] <= lvl_eff[i];
                if (grant[i]) begin
                    rem_reg[i] <= rem_reg[i] - SVC_W'(1);
                end
            end else if (proc && wr_hit[i] && !ready_reg[i] && svc_reg != '0) begin
                rem_reg[i] <= svc_reg;
                lvl_reg[i] <= '0;
                arr_reg[i] <= now_reg;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(fls_pkg::M_TDATA_W - fls_pkg::M_USED_W)'(0),
                       turn_reg, fin_time_reg, run_slot_reg};
    assign m_tuser  = {fin_reg, run_vld_reg};

endmodule

FILE: hdl/fls_checker.sv
// ----------------------------------------------------------------------------
// fls_checker
// Port-level checks on the result stream of the feedback level scheduler.
// ----------------------------------------------------------------------------
module fls_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fls_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [fls_pkg::M_TUSER_W-1:0] m_tuser
);

    // no result may be pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a finish can only be reported for a job that ran
    a_fin_ran: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[fls_pkg::M_FIN_BIT] |-> m_tuser[fls_pkg::M_RUN_BIT])
        else $error("finish without a running job");

    // idle tick reports all zero
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[fls_pkg::M_RUN_BIT] |-> m_tdata == '0)
        else $error("idle tick with nonzero data");

    // timing fields are zero unless the job finished
    a_nofin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[fls_pkg::M_FIN_BIT]
        |-> m_tdata[fls_pkg::M_TDATA_W-1:fls_pkg::M_FIN_LSB] == '0)
        else $error("timing fields set without a finish");

endmodule

bind feedback_level_scheduler_core fls_checker u_fls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: bench/feedback_level_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// feedback_level_scheduler_core_tb
// Streams admit and tick requests into the scheduler core and compares every
// tick result, field by field, against a cycle-free scheduler model kept in
// the bench. Directed cases come first, then random traffic under changing
// backpressure, then a tick run that drives two long jobs to the top level.
// ----------------------------------------------------------------------------
module feedback_level_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT  = 16;
    localparam int LEVEL_MAX   = 15;
    localparam int TIME_BITS   = 16;
    localparam int CYCLE_LIMIT = 1_000_000;

    // backpressure modes
    localparam logic [1:0] MODE_QUIET     = 2'd0;
    localparam logic [1:0] MODE_RX_STALLS = 2'd1;
    localparam logic [1:0] MODE_TX_GAPS   = 2'd2;
    localparam logic [1:0] MODE_FULL_RATE = 2'd3;

    typedef struct packed {
        fls_pkg::cmd_t                  cmd;
        logic [fls_pkg::SLOT_BITS-1:0]  slot;
        logic [fls_pkg::SVC_BITS-1:0]   svc;
        logic [1:0]                     mode;
    } sched_req_t;

    typedef struct packed {
        logic                              run_valid;
        logic [fls_pkg::SLOT_BITS-1:0]     run_slot;
        logic                              finished;
        logic [fls_pkg::OUT_TIME_BITS-1:0] done_time;
        logic [fls_pkg::OUT_TIME_BITS-1:0] turnaround;
    } tick_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [fls_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [fls_pkg::S_TUSER_W-1:0] s_tuser = fls_pkg::CMD_ADMIT;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [fls_pkg::M_TDATA_W-1:0] m_tdata;
    logic [fls_pkg::M_TUSER_W-1:0] m_tuser;

    feedback_level_scheduler_core #(
        .SLOT_COUNT (SLOT_COUNT),
        .LEVEL_MAX  (LEVEL_MAX),
        .TIME_BITS  (TIME_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // scheduler model state
    logic                          job_ready    [SLOT_COUNT];
    logic [fls_pkg::SVC_BITS-1:0]  units_left   [SLOT_COUNT];
    int                            job_level    [SLOT_COUNT];
    logic [TIME_BITS-1:0]          arrive_stamp [SLOT_COUNT];
    logic [TIME_BITS-1:0]          clock_now = '0;
    logic                          demote_due = 1'b0;
    int                            last_slot = 0;

    sched_req_t   pending_requests [$];
    tick_result_t expected_ticks   [$];
    sched_req_t   presented;
    int           fail_count = 0;
    int           cycle_count = 0;
    int           rx_stall_pct = 0;
    int           tx_gap_pct_of [4] = '{0, 21, 68, 0};
    int           rx_stall_pct_of [4] = '{0, 68, 21, 0};

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            job_ready[i] = 1'b0;
            units_left[i] = '0;
            job_level[i] = 0;
            arrive_stamp[i] = '0;
        end
    end

    // apply one accepted request to the model, queue the tick result if any
    task automatic schedule_request(input sched_req_t r);
        tick_result_t res;
        logic [TIME_BITS-1:0] fin;
        int pick;
        logic found;
        logic others;
        if (r.cmd == fls_pkg::CMD_ADMIT) begin
            if (!job_ready[r.slot] && r.svc != 0) begin
                job_ready[r.slot] = 1'b1;
                units_left[r.slot] = r.svc;
                job_level[r.slot] = 0;
                arrive_stamp[r.slot] = clock_now;
            end
        end else begin
            res = '0;
            // the previous runner sinks only if someone else is waiting
            if (demote_due && job_ready[last_slot]) begin
                others = 1'b0;
                for (int s = 0; s < SLOT_COUNT; s++)
                    if (s != last_slot && job_ready[s])
                        others = 1'b1;
                if (others && job_level[last_slot] < LEVEL_MAX)
                    job_level[last_slot]++;
            end
            demote_due = 1'b0;
            found = 1'b0;
            pick = 0;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (job_ready[s] && (!found || job_level[s] < job_level[pick])) begin
                    pick = s;
                    found = 1'b1;
                end
            end
            if (found) begin
                res.run_valid = 1'b1;
                res.run_slot = pick[fls_pkg::SLOT_BITS-1:0];
                units_left[pick] = units_left[pick] - 1'b1;
                last_slot = pick;
                if (units_left[pick] == 0) begin
                    fin = clock_now + 1'b1;
                    job_ready[pick] = 1'b0;
                    res.finished = 1'b1;
                    res.done_time = fin;
                    res.turnaround = fin - arrive_stamp[pick];
                end else begin
                    demote_due = 1'b1;
                end
            end
            clock_now = clock_now + 1'b1;
            expected_ticks.insert(expected_ticks.size(), res);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                schedule_request(presented);
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0
                    && $urandom_range(99) >= tx_gap_pct_of[pending_requests[0].mode]) begin
                    presented = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= fls_pkg::S_TDATA_W'({presented.svc, presented.slot});
                    s_tuser <= presented.cmd;
                    rx_stall_pct <= rx_stall_pct_of[presented.mode];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // monitor
    always @(posedge aclk) begin
        tick_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result with no tick request outstanding");
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    compare_field("run_valid", want.run_valid,
                                  m_tuser[fls_pkg::M_RUN_BIT]);
                    compare_field("run_slot", want.run_slot,
                                  m_tdata[fls_pkg::M_SLOT_LSB +: fls_pkg::SLOT_BITS]);
                    compare_field("finished", want.finished,
                                  m_tuser[fls_pkg::M_FIN_BIT]);
                    compare_field("done_time", want.done_time,
                                  m_tdata[fls_pkg::M_FIN_LSB +: fls_pkg::OUT_TIME_BITS]);
                    compare_field("turnaround", want.turnaround,
                                  m_tdata[fls_pkg::M_TURN_LSB +: fls_pkg::OUT_TIME_BITS]);
                end
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    task automatic add_admit(input int slot, input int svc, input logic [1:0] mode);
        sched_req_t r;
        r.cmd = fls_pkg::CMD_ADMIT;
        r.slot = slot[fls_pkg::SLOT_BITS-1:0];
        r.svc = svc[fls_pkg::SVC_BITS-1:0];
        r.mode = mode;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    task automatic add_tick(input logic [1:0] mode);
        sched_req_t r;
        r.cmd = fls_pkg::CMD_TICK;
        r.slot = fls_pkg::SLOT_BITS'($urandom_range(SLOT_COUNT - 1));
        r.svc = fls_pkg::SVC_BITS'($urandom);
        r.mode = mode;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    task automatic add_random_traffic(input int count, input logic [1:0] mode);
        int roll;
        int svc;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 40) begin
                roll = $urandom_range(99);
                if (roll < 3)
                    svc = $urandom_range(65535, 1);
                else if (roll < 8)
                    svc = 0;
                else
                    svc = $urandom_range(12, 1);
                add_admit($urandom_range(SLOT_COUNT - 1), svc, mode);
            end else begin
                add_tick(mode);
            end
        end
    endtask

    initial begin
        // idle tick, then admits; the zero-length one and the one to a busy slot are ignored
        add_tick(MODE_QUIET);
        add_admit(0, 0, MODE_QUIET);
        add_admit(15, 65535, MODE_QUIET);
        add_admit(0, 1, MODE_QUIET);
        add_admit(0, 3, MODE_QUIET);
        add_tick(MODE_QUIET);
        add_tick(MODE_QUIET);
        // slot 15 demoted once a competitor shows up
        add_admit(5, 2, MODE_QUIET);
        add_tick(MODE_QUIET);
        add_tick(MODE_QUIET);
        add_admit(10, 4, MODE_QUIET);
        add_admit(3, 3, MODE_QUIET);
        for (int k = 0; k < 10; k++)
            add_tick(MODE_QUIET);

        add_random_traffic(420, MODE_RX_STALLS);
        add_random_traffic(420, MODE_TX_GAPS);
        add_random_traffic(100, MODE_FULL_RATE);

        // two long jobs trade places until their levels saturate
        add_admit(1, 65535, MODE_FULL_RATE);
        add_admit(2, 65535, MODE_FULL_RATE);
        for (int k = 0; k < 40; k++)
            add_tick(MODE_FULL_RATE);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (expected_ticks.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: feedback_level_scheduler_core.f
hdl/fls_pkg.sv
hdl/fls_pick.sv
hdl/feedback_level_scheduler_core.sv
hdl/fls_checker.sv
bench/feedback_level_scheduler_core_tb.sv
